// ----- hw/rtl/bhfp_pkg.sv -----
// Shared types and constants for the bracket header frame parser.
package bhfp_pkg;

  localparam int unsigned MAX_TEXT = 32;
  localparam int unsigned CNT_W    = $clog2(MAX_TEXT + 1);
  localparam int unsigned ADDR_W   = (MAX_TEXT > 1) ? $clog2(MAX_TEXT) : 1;
  localparam int unsigned LEN_W    = 6;

  localparam logic [7:0] CH_OPEN  = 8'h5B;
  localparam logic [7:0] CH_CLOSE = 8'h5D;
  localparam logic [7:0] CH_CMD   = 8'h53;
  localparam logic [7:0] CH_TEXT  = 8'h54;
  localparam logic [7:0] CH_END   = 8'h40;

  typedef enum logic [1:0] {
    KIND_CMD  = 2'd0,
    KIND_TEXT = 2'd1,
    KIND_END  = 2'd2
  } kind_e;

  // One unit of work handed from the front to the back.
  typedef struct packed {
    logic             is_text;
    logic [7:0]       data;
    logic [CNT_W-1:0] count;
  } job_t;

  // Text store write port.
  typedef struct packed {
    logic              en;
    logic [ADDR_W-1:0] addr;
    logic [7:0]        data;
  } wr_t;

endpackage

// ----- hw/rtl/bhfp_front.sv -----
// Front end: header search, text capture and job generation.
module bhfp_front (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic [7:0]           rx_byte_i,
  input  logic                 fifo_full_i,
  output logic                 push_o,
  output bhfp_pkg::job_t       job_o,
  output bhfp_pkg::wr_t        wr_o,
  input  logic                 text_done_i
);

  typedef enum logic [1:0] {
    S_HUNT,
    S_OPEN,
    S_KIND,
    S_BODY
  } state_e;

  state_e                       state_q, state_d;
  logic                         is_text_q, is_text_d;
  logic [bhfp_pkg::CNT_W-1:0]   count_q, count_d;
  logic                         pend_q, pend_d;
  logic                         accept;
  logic                         msg_end;

  // Store is shared with the playout side, so text bytes wait while a run is pending.
  assign in_stall_o = (state_q == S_BODY) && (fifo_full_i || (is_text_q && pend_q));
  assign accept     = in_valid_i && !in_stall_o;
  assign msg_end    = (rx_byte_i == bhfp_pkg::CH_END) ||
                      (count_q >= bhfp_pkg::CNT_W'(bhfp_pkg::MAX_TEXT));

  always_comb begin
    state_d      = state_q;
    is_text_d    = is_text_q;
    count_d      = count_q;
    pend_d       = pend_q;
    push_o       = 1'b0;
    job_o        = '0;
    wr_o         = '0;
    wr_o.addr    = count_q[bhfp_pkg::ADDR_W-1:0];
    wr_o.data    = rx_byte_i;
    if (text_done_i) begin
      pend_d = 1'b0;
    end
    if (accept) begin
      case (state_q)
        S_BODY: begin
          state_d = S_HUNT;
          if (!is_text_q) begin
            push_o       = 1'b1;
            job_o.data   = rx_byte_i;
          end else if (msg_end) begin
            push_o        = 1'b1;
            job_o.is_text = 1'b1;
            job_o.count   = count_q;
            count_d       = '0;
            pend_d        = 1'b1;
          end else begin
            wr_o.en = 1'b1;
            count_d = count_q + bhfp_pkg::CNT_W'(1);
            state_d = S_BODY;
          end
        end
        default: begin
          if (rx_byte_i == bhfp_pkg::CH_OPEN) begin
            state_d = S_OPEN;
            count_d = '0;
          end else if (state_q == S_OPEN &&
                       (rx_byte_i == bhfp_pkg::CH_CMD || rx_byte_i == bhfp_pkg::CH_TEXT)) begin
            state_d   = S_KIND;
            is_text_d = (rx_byte_i == bhfp_pkg::CH_TEXT);
          end else if (state_q == S_KIND && rx_byte_i == bhfp_pkg::CH_CLOSE) begin
            state_d = S_BODY;
          end else begin
            state_d = S_HUNT;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_HUNT;
      is_text_q <= 1'b0;
      count_q   <= '0;
      pend_q    <= 1'b0;
    end else begin
      state_q   <= state_d;
      is_text_q <= is_text_d;
      count_q   <= count_d;
      pend_q    <= pend_d;
    end
  end

endmodule

// ----- hw/rtl/bhfp_fifo.sv -----
// Two-entry job queue between front and back.
module bhfp_fifo (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  bhfp_pkg::job_t job_i,
  output logic           full_o,
  input  logic           pop_i,
  output logic           empty_o,
  output bhfp_pkg::job_t job_o
);

  bhfp_pkg::job_t mem_q [2];
  logic           wptr_q, rptr_q;
  logic [1:0]     cnt_q;

  assign full_o  = (cnt_q == 2'd2);
  assign empty_o = (cnt_q == 2'd0);
  assign job_o   = mem_q[rptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wptr_q] <= job_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= 1'b0;
      rptr_q <= 1'b0;
      cnt_q  <= 2'd0;
    end else begin
      if (push_i) wptr_q <= !wptr_q;
      if (pop_i)  rptr_q <= !rptr_q;
      case ({push_i, pop_i})
        2'b10:   cnt_q <= cnt_q + 2'd1;
        2'b01:   cnt_q <= cnt_q - 2'd1;
        default: cnt_q <= cnt_q;
      endcase
    end
  end

endmodule

// ----- hw/rtl/bhfp_back.sv -----
// Back end: text store, playout sequencer and output register.
module bhfp_back (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  bhfp_pkg::wr_t               wr_i,
  input  logic                        empty_i,
  input  bhfp_pkg::job_t              job_i,
  output logic                        pop_o,
  output logic                        text_done_o,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic [1:0]                  kind_o,
  output logic [7:0]                  data_o,
  output logic [bhfp_pkg::LEN_W-1:0]  length_o,
  output logic                        last_o
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_READ,
    S_SEND,
    S_END
  } state_e;

  logic [7:0]                 store_q [bhfp_pkg::MAX_TEXT];
  logic [7:0]                 rdata_q;
  state_e                     state_q;
  logic [bhfp_pkg::CNT_W-1:0] idx_q;
  logic [bhfp_pkg::CNT_W-1:0] len_q;
  logic                       valid_q;
  bhfp_pkg::kind_e            kind_q;
  logic [7:0]                 data_q;
  logic [bhfp_pkg::LEN_W-1:0] length_q;
  logic                       last_q;
  logic                       slot_free;
  logic                       load;

  assign slot_free   = !valid_q || !out_stall_i;
  assign pop_o       = (state_q == S_IDLE) && !empty_i && (job_i.is_text || slot_free);
  assign text_done_o = (state_q == S_END) && slot_free;
  // output register takes a new record this cycle
  assign load        = slot_free && ((state_q == S_SEND) || (state_q == S_END) ||
                                     (pop_o && !job_i.is_text));

  assign out_valid_o = valid_q;
  assign kind_o      = kind_q;
  assign data_o      = data_q;
  assign length_o    = length_q;
  assign last_o      = last_q;

  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      store_q[wr_i.addr] <= wr_i.data;
    end
    rdata_q <= store_q[idx_q[bhfp_pkg::ADDR_W-1:0]];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      idx_q    <= '0;
      len_q    <= '0;
      valid_q  <= 1'b0;
      kind_q   <= bhfp_pkg::KIND_CMD;
      data_q   <= '0;
      length_q <= '0;
      last_q   <= 1'b0;
    end else begin
      if (load) begin
        valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (pop_o) begin
            if (job_i.is_text) begin
              len_q   <= job_i.count;
              idx_q   <= '0;
              state_q <= (job_i.count == '0) ? S_END : S_READ;
            end else begin
              kind_q   <= bhfp_pkg::KIND_CMD;
              data_q   <= job_i.data;
              length_q <= '0;
              last_q   <= 1'b1;
            end
          end
        end
        // store read is registered into rdata_q, ready for S_SEND
        S_READ: state_q <= S_SEND;
        S_SEND: begin
          if (slot_free) begin
            kind_q   <= bhfp_pkg::KIND_TEXT;
            data_q   <= rdata_q;
            length_q <= '0;
            last_q   <= 1'b0;
            idx_q    <= idx_q + bhfp_pkg::CNT_W'(1);
            state_q  <= ((idx_q + bhfp_pkg::CNT_W'(1)) == len_q) ? S_END : S_READ;
          end
        end
        S_END: begin
          if (slot_free) begin
            kind_q   <= bhfp_pkg::KIND_END;
            data_q   <= '0;
            length_q <= bhfp_pkg::LEN_W'(len_q);
            last_q   <= 1'b1;
            state_q  <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

endmodule

// ----- hw/rtl/bracket_header_frame_parser.sv -----
// Top level of the bracket header frame parser: front, job queue, back.
// A command byte passes through the job queue into the output register; a text run starts
// once popped: each text byte is read (S_READ) and sent (S_SEND), then the end record.
// Throughput: 1 byte per cycle in header search and in capture while not stalled; text
// bytes of a new message stall while the last run plays out of the shared 32-entry store.
// Reset: asynchronous, active low; clears control state, the store is not cleared.
module bracket_header_frame_parser (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic [7:0]                  rx_byte_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic [1:0]                  kind_o,
  output logic [7:0]                  data_o,
  output logic [bhfp_pkg::LEN_W-1:0]  length_o,
  output logic                        last_o
);

  logic           fifo_full, fifo_empty, push, pop, text_done;
  bhfp_pkg::job_t push_job, pop_job;
  bhfp_pkg::wr_t  wr;

  bhfp_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .rx_byte_i   (rx_byte_i),
    .fifo_full_i (fifo_full),
    .push_o      (push),
    .job_o       (push_job),
    .wr_o        (wr),
    .text_done_i (text_done)
  );

  bhfp_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .job_i   (push_job),
    .full_o  (fifo_full),
    .pop_i   (pop),
    .empty_o (fifo_empty),
    .job_o   (pop_job)
  );

  bhfp_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .wr_i        (wr),
    .empty_i     (fifo_empty),
    .job_i       (pop_job),
    .pop_o       (pop),
    .text_done_o (text_done),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .kind_o      (kind_o),
    .data_o      (data_o),
    .length_o    (length_o),
    .last_o      (last_o)
  );

`ifndef ASSERT_OFF
  a_no_push_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(push && fifo_full && !pop))
    else $error("job pushed into full queue");

  a_no_pop_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(pop && fifo_empty))
    else $error("job popped from empty queue");

  a_end_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && kind_o == bhfp_pkg::KIND_END) |-> (last_o && data_o == 8'd0))
    else $error("end record malformed");

  a_text_not_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && kind_o == bhfp_pkg::KIND_TEXT) |-> (!last_o && length_o == '0))
    else $error("text record malformed");
`endif

endmodule
